[hdl/sorted_set_insert_delete_assert.svh]
// Assertion macros shared by the sorted set RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SORTED_SET_INSERT_DELETE_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTH

// Property checked while the block is out of reset.
`define SSID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define SSID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SSID_ASSERT(lbl, prop, msg)
`define SSID_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hdl/ssid_pkg.sv]
// Shared types and constants for the sorted set block.
// Used by ssid_outreg and sorted_set_insert_delete; depends on nothing.
package ssid_pkg;

  // Key and stored value width.
  localparam int KEY_W = 32;

  // Operation codes carried on the input tuser.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // One result word as it travels to the output register.
  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic                    is_empty;
    logic                    last;
    logic                    dropped;
  } out_word_t;

endpackage

[hdl/sorted_set_insert_delete.sv]
// Sorted set of distinct signed 32-bit keys held in ascending order in one
// synchronous store of CAPACITY words. Each input word inserts or deletes a
// key; afterwards the whole set is sent out in ascending order, the last word
// marked by tlast, an empty set as one word with the empty flag. An insert of
// a new key into a full set is discarded and every word of that run carries
// the dropped flag; a delete from an empty set gives no output at all. An
// operation runs an update pass that reads the store one word a cycle and
// writes the shifted words back, a finishing step that writes the tail word
// of an insert and the new occupancy, then an emit pass that reads the store
// again one word a cycle while the output register is free. Both passes use
// the single read port of the store.
`include "sorted_set_insert_delete_assert.svh"

module sorted_set_insert_delete
  import ssid_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [KEY_W-1:0] in_tdata,   // key
  input  logic             in_tuser,   // action
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [KEY_W-1:0] out_tdata,  // value
  output logic [1:0]       out_tuser,  // is_empty, dropped
  output logic             out_tlast   // last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    M_SEARCH = 3'b001,
    M_SHIFT  = 3'b010,
    M_DONE   = 3'b100
  } mode_t;

  state_t                  state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic                    act_r, act_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [OW-1:0]           occ_r, occ_nxt;
  logic [OW-1:0]           cnt_r, cnt_nxt;
  logic                    dv_r, dv_nxt;
  logic [AW-1:0]           di_r, di_nxt;
  logic signed [KEY_W-1:0] carry_r, carry_nxt;
  logic                    drop_r, drop_nxt;
  logic                    pv_r, pv_nxt;
  logic [AW-1:0]           pidx_r, pidx_nxt;

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rdata_r;
  logic                    rd_en;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  logic                    out_free;
  logic                    out_load;
  out_word_t               out_word;
  logic                    full;
  logic                    issue;
  logic                    move;
  logic                    is_last;

  assign full      = (occ_r == OW'(CAPACITY));
  assign in_tready = (state_r == ST_IDLE);

  // Sequencer: update pass, write-back of the tail word, then emit pass.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    act_nxt   = act_r;
    key_nxt   = key_r;
    occ_nxt   = occ_r;
    cnt_nxt   = cnt_r;
    dv_nxt    = 1'b0;
    di_nxt    = di_r;
    carry_nxt = carry_r;
    drop_nxt  = drop_r;
    pv_nxt    = pv_r;
    pidx_nxt  = pidx_r;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = di_r;
    wr_data   = key_r;
    out_load  = 1'b0;
    out_word  = '0;
    issue     = 1'b0;
    move      = 1'b0;
    is_last   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt  = in_tuser;
          key_nxt  = signed'(in_tdata);
          mode_nxt = M_SEARCH;
          drop_nxt = 1'b0;
          cnt_nxt  = '0;
          pv_nxt   = 1'b0;
          if (!(in_tuser == ACT_DELETE && occ_r == '0)) begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Read one stored word a cycle.
        issue = (cnt_r < occ_r);
        rd_en = issue;
        if (issue) begin
          cnt_nxt = cnt_r + OW'(1);
        end
        dv_nxt = issue;
        di_nxt = cnt_r[AW-1:0];

        // Act on the word read in the previous cycle.
        if (dv_r) begin
          if (act_r == ACT_INSERT) begin
            case (mode_r)
              M_SEARCH: begin
                if (rdata_r == key_r) begin
                  mode_nxt = M_DONE;
                end else if (rdata_r > key_r) begin
                  if (full) begin
                    drop_nxt = 1'b1;
                    mode_nxt = M_DONE;
                  end else begin
                    wr_en     = 1'b1;
                    wr_addr   = di_r;
                    wr_data   = key_r;
                    carry_nxt = rdata_r;
                    mode_nxt  = M_SHIFT;
                  end
                end
              end
              M_SHIFT: begin
                // Each word moves up one place.
                wr_en     = 1'b1;
                wr_addr   = di_r;
                wr_data   = carry_r;
                carry_nxt = rdata_r;
              end
              default: begin
              end
            endcase
          end else begin
            case (mode_r)
              M_SEARCH: begin
                if (rdata_r == key_r) begin
                  mode_nxt = M_SHIFT;
                end
              end
              M_SHIFT: begin
                // Each word above the removed key moves down one place.
                wr_en   = 1'b1;
                wr_addr = di_r - AW'(1);
                wr_data = rdata_r;
              end
              default: begin
              end
            endcase
          end
        end

        // The last word read is handled in this cycle, so the pass ends here.
        if (!issue) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Tail word of an insert and the new occupancy.
        if (act_r == ACT_INSERT) begin
          if (mode_r == M_SHIFT) begin
            wr_en   = 1'b1;
            wr_addr = occ_r[AW-1:0];
            wr_data = carry_r;
            occ_nxt = occ_r + OW'(1);
          end else if (mode_r == M_SEARCH) begin
            if (full) begin
              drop_nxt = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = occ_r[AW-1:0];
              wr_data = key_r;
              occ_nxt = occ_r + OW'(1);
            end
          end
        end else if (mode_r == M_SHIFT) begin
          occ_nxt = occ_r - OW'(1);
        end
        cnt_nxt   = '0;
        pv_nxt    = 1'b0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (occ_r == '0) begin
          // Empty set: a single flagged word.
          if (out_free) begin
            out_load         = 1'b1;
            out_word.value   = '0;
            out_word.is_empty = 1'b1;
            out_word.last    = 1'b1;
            out_word.dropped = drop_r;
            state_nxt        = ST_IDLE;
          end
        end else begin
          // Read ahead by one word, held until the output register is free.
          move    = pv_r && out_free;
          is_last = (OW'(pidx_r) == occ_r - OW'(1));
          issue   = (cnt_r < occ_r) && (!pv_r || move);
          rd_en   = issue;
          if (issue) begin
            cnt_nxt  = cnt_r + OW'(1);
            pidx_nxt = cnt_r[AW-1:0];
          end
          if (move) begin
            out_load          = 1'b1;
            out_word.value    = rdata_r;
            out_word.is_empty = 1'b0;
            out_word.last     = is_last;
            out_word.dropped  = drop_r;
            if (is_last) begin
              state_nxt = ST_IDLE;
            end
          end
          pv_nxt = issue ? 1'b1 : (move ? 1'b0 : pv_r);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= M_SEARCH;
      occ_r   <= '0;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      drop_r  <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      occ_r   <= occ_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
      drop_r  <= drop_nxt;
      pv_r    <= pv_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    key_r   <= key_nxt;
    di_r    <= di_nxt;
    carry_r <= carry_nxt;
    pidx_r  <= pidx_nxt;
  end

  // Key store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[cnt_r[AW-1:0]];
    end
  end

  ssid_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (out_load),
    .word_i     (out_word),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Checks.
  `SSID_ASSERT(a_occ_bound, occ_r <= OW'(CAPACITY), "occupancy above capacity")
  `SSID_ASSERT(a_wr_phase, wr_en |-> (state_r == ST_SCAN || state_r == ST_FINISH), "stray write")
  `SSID_ASSERT(a_cnt_bound, cnt_r <= occ_r, "read counter past occupancy")
  `SSID_ASSERT(a_drop_full, (state_r == ST_EMIT && drop_r) |-> full, "drop while not full")
  `SSID_ASSERT(a_idle_clean, (state_r == ST_IDLE) |-> (!pv_r && !dv_r), "stale read when idle")

endmodule

[hdl/ssid_outreg.sv]
// Output register for the sorted set result stream.
// Depends on ssid_pkg for the result word type.
module ssid_outreg
  import ssid_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_i,
  input  out_word_t       word_i,
  output logic            free_o,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [KEY_W-1:0] out_tdata,  // value
  output logic [1:0]      out_tuser,   // is_empty, dropped
  output logic            out_tlast    // last
);

  logic      valid_r;
  out_word_t word_r;

  // The register can take a new word when empty or when its word leaves now.
  assign free_o = !valid_r || out_tready;

  // Valid flag: set on load, cleared once the word has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load_i) begin
      word_r <= word_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = KEY_W'(unsigned'(word_r.value));
  assign out_tuser  = {word_r.dropped, word_r.is_empty};
  assign out_tlast  = word_r.last;

endmodule
